// File: hw/rtl/rsp_pkg.sv
// Shared types and constants for the RESP reply stream parser.
`default_nettype none

package rsp_pkg;

    // Width of the signed size value; the accumulator holds its magnitude, and overflow is judged against this width
    localparam int SIZE_BITS = 32;
    localparam int ACC_W     = SIZE_BITS + 4;

    // Magnitude limit 2^(SIZE_BITS-1)
    localparam logic [SIZE_BITS-1:0] SIZE_LIMIT = {1'b1, {(SIZE_BITS - 1){1'b0}}};

    // Value type codes
    localparam logic [2:0] VT_SIMPLE  = 3'd0;
    localparam logic [2:0] VT_ERROR   = 3'd1;
    localparam logic [2:0] VT_INTEGER = 3'd2;
    localparam logic [2:0] VT_BULK    = 3'd3;
    localparam logic [2:0] VT_ARRAY   = 3'd4;
    localparam logic [2:0] VT_UNKNOWN = 3'd5;

    // Item kinds
    localparam logic ITEM_HEADER  = 1'b0;
    localparam logic ITEM_CONTENT = 1'b1;

    // Number status codes
    localparam logic [1:0] NS_OK       = 2'd0;
    localparam logic [1:0] NS_NODIGITS = 2'd1;
    localparam logic [1:0] NS_OVERFLOW = 2'd2;

    // Protocol characters
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Parser phase, one-hot
    typedef enum logic [3:0] {
        PH_TYPE    = 4'b0001,
        PH_LINE    = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_TRAILER = 4'b1000
    } phase_t;

endpackage

`default_nettype wire

// File: hw/rtl/resp_stream_parser_core.sv
// RESP reply stream parser: byte input register, parser state, result register.
// A byte that yields a result passes from the input register through the parser update into the result register.
// Throughput: one byte per cycle; the single-pass parser update between the input
// register and the result register sets this, and out_stall backs up through both stages.
// Reset (rst_n low, asynchronous): both stages empty, parser waits for a type byte,
// all line state cleared.
`default_nettype none

module resp_stream_parser_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [7:0]          in_byte,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     item_kind,
    output logic [2:0]               value_type,
    output logic signed [31:0]       size_value,
    output logic [7:0]               content_byte,
    output logic                     last_content,
    output logic [1:0]               number_status
);

    // Input stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Parser state
    rsp_pkg::phase_t                phase_reg, phase_next;
    logic [2:0]                     line_type_reg, line_type_next;
    logic                           is_negative_reg, is_negative_next;
    logic [rsp_pkg::SIZE_BITS-1:0]  number_acc_reg, number_acc_next;
    logic                           digits_seen_reg, digits_seen_next;
    logic                           number_ended_reg, number_ended_next;
    logic                           overflowed_reg, overflowed_next;
    logic                           first_after_type_reg, first_after_type_next;
    logic                           null_bulk_reg, null_bulk_next;
    logic                           pending_cr_reg, pending_cr_next;
    logic [30:0]                    payload_left_reg, payload_left_next;
    logic [1:0]                     trailer_left_reg, trailer_left_next;

    // Result register
    logic        out_valid_reg;
    logic        item_kind_reg, item_kind_next;
    logic [2:0]  value_type_reg, value_type_next;
    logic [31:0] size_value_reg, size_value_next;
    logic [7:0]  content_byte_reg, content_byte_next;
    logic        last_content_reg, last_content_next;
    logic [1:0]  number_status_reg, number_status_next;
    logic        emit;

    // Pipeline control
    logic advance;
    logic proc_fire;

    assign advance   = !out_valid_reg || !out_stall;
    assign proc_fire = in_valid_reg && advance;
    assign in_stall  = in_valid_reg && !advance;

    // Decimal accumulate: acc*10 + digit, checked against the limit
    logic [rsp_pkg::ACC_W-1:0] acc_wide;
    logic [rsp_pkg::ACC_W-1:0] acc_step;
    logic [rsp_pkg::ACC_W-1:0] limit_wide;
    logic                      step_over;
    logic                      is_digit;

    assign acc_wide   = rsp_pkg::ACC_W'(number_acc_reg);
    assign acc_step   = (acc_wide << 3) + (acc_wide << 1)
                        + rsp_pkg::ACC_W'(in_byte_reg[3:0]);
    assign limit_wide = rsp_pkg::ACC_W'(rsp_pkg::SIZE_LIMIT);
    assign step_over  = acc_step > limit_wide;
    assign is_digit   = (in_byte_reg >= rsp_pkg::CH_ZERO) && (in_byte_reg <= rsp_pkg::CH_NINE);

    // Header number result from the current line state
    logic [1:0]                    num_status;
    logic [rsp_pkg::SIZE_BITS-1:0] num_signed;
    logic signed [63:0]            num_ext;

    always_comb
    begin
        if (!digits_seen_reg)
            num_status = rsp_pkg::NS_NODIGITS;
        else if (overflowed_reg || (!is_negative_reg && number_acc_reg == rsp_pkg::SIZE_LIMIT))
            num_status = rsp_pkg::NS_OVERFLOW;
        else
            num_status = rsp_pkg::NS_OK;
    end

    assign num_signed = (num_status != rsp_pkg::NS_OK) ? '0 :
                        (is_negative_reg ? (~number_acc_reg + 1'b1) : number_acc_reg);
    assign num_ext    = 64'(signed'(num_signed));

    // Parser step
    always_comb
    begin
        phase_next            = phase_reg;
        line_type_next        = line_type_reg;
        is_negative_next      = is_negative_reg;
        number_acc_next       = number_acc_reg;
        digits_seen_next      = digits_seen_reg;
        number_ended_next     = number_ended_reg;
        overflowed_next       = overflowed_reg;
        first_after_type_next = first_after_type_reg;
        null_bulk_next        = null_bulk_reg;
        pending_cr_next       = pending_cr_reg;
        payload_left_next     = payload_left_reg;
        trailer_left_next     = trailer_left_reg;

        emit                  = 1'b0;
        item_kind_next        = rsp_pkg::ITEM_HEADER;
        value_type_next       = rsp_pkg::VT_SIMPLE;
        size_value_next       = '0;
        content_byte_next     = '0;
        last_content_next     = 1'b0;
        number_status_next    = rsp_pkg::NS_OK;

        if (proc_fire)
        begin
            unique case (phase_reg)
                rsp_pkg::PH_TYPE:
                begin
                    unique case (in_byte_reg)
                        rsp_pkg::CH_PLUS:   line_type_next = rsp_pkg::VT_SIMPLE;
                        rsp_pkg::CH_MINUS:  line_type_next = rsp_pkg::VT_ERROR;
                        rsp_pkg::CH_COLON:  line_type_next = rsp_pkg::VT_INTEGER;
                        rsp_pkg::CH_DOLLAR: line_type_next = rsp_pkg::VT_BULK;
                        rsp_pkg::CH_STAR:   line_type_next = rsp_pkg::VT_ARRAY;
                        default:            line_type_next = rsp_pkg::VT_UNKNOWN;
                    endcase
                    is_negative_next      = 1'b0;
                    number_acc_next       = '0;
                    digits_seen_next      = 1'b0;
                    number_ended_next     = 1'b0;
                    overflowed_next       = 1'b0;
                    first_after_type_next = 1'b1;
                    null_bulk_next        = 1'b0;
                    pending_cr_next       = 1'b0;
                    phase_next            = rsp_pkg::PH_LINE;
                end

                rsp_pkg::PH_PAYLOAD:
                begin
                    emit              = 1'b1;
                    item_kind_next    = rsp_pkg::ITEM_CONTENT;
                    value_type_next   = rsp_pkg::VT_BULK;
                    content_byte_next = in_byte_reg;
                    if (payload_left_reg <= 31'd1)
                    begin
                        last_content_next = 1'b1;
                        payload_left_next = '0;
                        trailer_left_next = 2'd2;
                        phase_next        = rsp_pkg::PH_TRAILER;
                    end
                    else
                    begin
                        payload_left_next = payload_left_reg - 31'd1;
                    end
                end

                rsp_pkg::PH_TRAILER:
                begin
                    if (trailer_left_reg > 2'd1)
                        trailer_left_next = trailer_left_reg - 2'd1;
                    else
                    begin
                        trailer_left_next = '0;
                        phase_next        = rsp_pkg::PH_TYPE;
                    end
                end

                rsp_pkg::PH_LINE:
                begin
                    priority if (pending_cr_reg && in_byte_reg == rsp_pkg::CH_LF)
                    begin
                        // CR LF: line complete, emit header
                        pending_cr_next = 1'b0;
                        phase_next      = rsp_pkg::PH_TYPE;
                        emit            = 1'b1;
                        if (line_type_reg == rsp_pkg::VT_SIMPLE
                            || line_type_reg == rsp_pkg::VT_ERROR)
                        begin
                            value_type_next = line_type_reg;
                            size_value_next = 32'd1;
                        end
                        else if (line_type_reg > rsp_pkg::VT_ARRAY)
                        begin
                            value_type_next = rsp_pkg::VT_UNKNOWN;
                        end
                        else if (line_type_reg == rsp_pkg::VT_BULK && null_bulk_reg)
                        begin
                            value_type_next = rsp_pkg::VT_ERROR;
                        end
                        else
                        begin
                            value_type_next    = line_type_reg;
                            size_value_next    = num_ext[31:0];
                            number_status_next = num_status;
                            if (line_type_reg == rsp_pkg::VT_BULK
                                && num_status == rsp_pkg::NS_OK)
                            begin
                                payload_left_next = num_ext[30:0];
                                if (num_ext[30:0] != '0)
                                    phase_next = rsp_pkg::PH_PAYLOAD;
                                else
                                begin
                                    trailer_left_next = 2'd2;
                                    phase_next        = rsp_pkg::PH_TRAILER;
                                end
                            end
                        end
                    end
                    else if (in_byte_reg == rsp_pkg::CH_CR)
                    begin
                        // CR held pending; it ends a number
                        pending_cr_next = 1'b1;
                        if (line_type_reg >= rsp_pkg::VT_INTEGER
                            && line_type_reg <= rsp_pkg::VT_ARRAY)
                        begin
                            number_ended_next     = 1'b1;
                            first_after_type_next = 1'b0;
                        end
                    end
                    else
                    begin
                        pending_cr_next = 1'b0;
                        first_after_type_next = 1'b0;
                        if (line_type_reg == rsp_pkg::VT_SIMPLE
                            || line_type_reg == rsp_pkg::VT_ERROR)
                        begin
                            // Text byte of a simple string or error
                            emit              = 1'b1;
                            item_kind_next    = rsp_pkg::ITEM_CONTENT;
                            value_type_next   = line_type_reg;
                            content_byte_next = in_byte_reg;
                        end
                        else if (line_type_reg <= rsp_pkg::VT_ARRAY && !null_bulk_reg)
                        begin
                            // Numeric line byte: sign, digit or terminator
                            priority if (first_after_type_reg
                                         && line_type_reg == rsp_pkg::VT_BULK
                                         && in_byte_reg == rsp_pkg::CH_MINUS)
                                null_bulk_next = 1'b1;
                            else if (first_after_type_reg
                                     && (in_byte_reg == rsp_pkg::CH_PLUS
                                         || in_byte_reg == rsp_pkg::CH_MINUS))
                                is_negative_next = (in_byte_reg == rsp_pkg::CH_MINUS);
                            else if (!number_ended_reg && is_digit)
                            begin
                                digits_seen_next = 1'b1;
                                if (!overflowed_reg)
                                begin
                                    if (step_over)
                                        overflowed_next = 1'b1;
                                    else
                                        number_acc_next = acc_step[rsp_pkg::SIZE_BITS-1:0];
                                end
                            end
                            else
                                number_ended_next = 1'b1;
                        end
                    end
                end

                default:
                begin
                    phase_next = rsp_pkg::PH_TYPE;
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            in_byte_reg <= in_byte;
    end

    // Parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= rsp_pkg::PH_TYPE;
            line_type_reg        <= '0;
            is_negative_reg      <= 1'b0;
            number_acc_reg       <= '0;
            digits_seen_reg      <= 1'b0;
            number_ended_reg     <= 1'b0;
            overflowed_reg       <= 1'b0;
            first_after_type_reg <= 1'b0;
            null_bulk_reg        <= 1'b0;
            pending_cr_reg       <= 1'b0;
            payload_left_reg     <= '0;
            trailer_left_reg     <= '0;
        end
        else
        begin
            phase_reg            <= phase_next;
            line_type_reg        <= line_type_next;
            is_negative_reg      <= is_negative_next;
            number_acc_reg       <= number_acc_next;
            digits_seen_reg      <= digits_seen_next;
            number_ended_reg     <= number_ended_next;
            overflowed_reg       <= overflowed_next;
            first_after_type_reg <= first_after_type_next;
            null_bulk_reg        <= null_bulk_next;
            pending_cr_reg       <= pending_cr_next;
            payload_left_reg     <= payload_left_next;
            trailer_left_reg     <= trailer_left_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= proc_fire && emit;
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && emit)
        begin
            item_kind_reg     <= item_kind_next;
            value_type_reg    <= value_type_next;
            size_value_reg    <= size_value_next;
            content_byte_reg  <= content_byte_next;
            last_content_reg  <= last_content_next;
            number_status_reg <= number_status_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign item_kind     = item_kind_reg;
    assign value_type    = value_type_reg;
    assign size_value    = signed'(size_value_reg);
    assign content_byte  = content_byte_reg;
    assign last_content  = last_content_reg;
    assign number_status = number_status_reg;

endmodule

`default_nettype wire

// File: bench/tb_resp_stream_parser_core.sv
// Self-checking testbench for the RESP reply stream parser core.
`timescale 1ns / 100ps

module tb_resp_stream_parser_core;

    import rsp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int RANDOM_BYTES   = 340;
    localparam int MAX_PRINTED    = 20;

    // Largest magnitude a signed SIZE_BITS number may reach
    localparam logic [63:0] MAG_LIMIT = 64'd1 << (SIZE_BITS - 1);

    // Receiver stall styles
    typedef enum int {RX_READY, RX_RANDOM, RX_PATTERN} rx_mode_e;

    // One parser result, as seen on the output ports
    typedef struct packed {
        logic        kind;
        logic [2:0]  vtype;
        logic [31:0] size_val;
        logic [7:0]  data;
        logic        last_flag;
        logic [1:0]  status;
    } resp_item_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         in_byte;
    logic               out_valid;
    logic               out_stall;
    logic               item_kind;
    logic [2:0]         value_type;
    logic signed [31:0] size_value;
    logic [7:0]         content_byte;
    logic               last_content;
    logic [1:0]         number_status;

    // Predicted parser state
    phase_t      ps_phase;
    logic [2:0]  cur_type;
    logic        neg;
    logic [63:0] acc;
    logic        got_digit;
    logic        num_done;
    logic        ovf;
    logic        at_first;
    logic        null_blk;
    logic        cr_held;
    logic [30:0] pay_left;
    logic [1:0]  trail_left;

    resp_item_t pending_results[$];
    resp_item_t seen_item;
    resp_item_t want_item;
    resp_item_t new_item;

    int       mismatch_count;
    int       bytes_sent;
    int       bytes_in;
    int       results_seen;
    int       headers_seen;
    int       contents_seen;
    int       idle_count;
    int       burst_left;
    int       gap_max;
    rx_mode_e rx_mode;
    logic [15:0] stall_pat;
    logic [3:0]  pat_pos;

    resp_stream_parser_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .item_kind     (item_kind),
        .value_type    (value_type),
        .size_value    (size_value),
        .content_byte  (content_byte),
        .last_content  (last_content),
        .number_status (number_status)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic resp_item_t make_item(input logic kind, input logic [2:0] vtype,
                                             input logic [31:0] size_val, input logic [7:0] data,
                                             input logic last_flag, input logic [1:0] status);
        resp_item_t r;
        r.kind      = kind;
        r.vtype     = vtype;
        r.size_val  = size_val;
        r.data      = data;
        r.last_flag = last_flag;
        r.status    = status;
        return r;
    endfunction

    // Advance the predicted parser by one byte; returns 1 when a result is due
    function automatic bit parse_byte(input logic [7:0] b, output resp_item_t r);
        logic [63:0] digit;
        logic [63:0] val;
        logic [1:0]  status;
        logic        is_last;
        r = make_item(ITEM_HEADER, VT_SIMPLE, 32'd0, 8'd0, 1'b0, NS_OK);

        // type byte opens a new value
        if (ps_phase == PH_TYPE)
        begin
            case (b)
                CH_PLUS:   cur_type = VT_SIMPLE;
                CH_MINUS:  cur_type = VT_ERROR;
                CH_COLON:  cur_type = VT_INTEGER;
                CH_DOLLAR: cur_type = VT_BULK;
                CH_STAR:   cur_type = VT_ARRAY;
                default:   cur_type = VT_UNKNOWN;
            endcase
            neg       = 1'b0;
            acc       = '0;
            got_digit = 1'b0;
            num_done  = 1'b0;
            ovf       = 1'b0;
            at_first  = 1'b1;
            null_blk  = 1'b0;
            cr_held   = 1'b0;
            ps_phase  = PH_LINE;
            return 1'b0;
        end

        // bulk payload bytes pass straight through
        if (ps_phase == PH_PAYLOAD)
        begin
            is_last = (pay_left <= 31'd1);
            r = make_item(ITEM_CONTENT, VT_BULK, 32'd0, b, is_last, NS_OK);
            if (is_last)
            begin
                pay_left   = '0;
                trail_left = 2'd2;
                ps_phase   = PH_TRAILER;
            end
            else
                pay_left = pay_left - 31'd1;
            return 1'b1;
        end

        // two trailer bytes dropped unchecked
        if (ps_phase == PH_TRAILER)
        begin
            if (trail_left > 2'd1)
                trail_left = trail_left - 2'd1;
            else
            begin
                trail_left = 2'd0;
                ps_phase   = PH_TYPE;
            end
            return 1'b0;
        end

        // CR LF closes the header line
        if (cr_held && b == CH_LF)
        begin
            cr_held  = 1'b0;
            ps_phase = PH_TYPE;
            if (cur_type == VT_SIMPLE || cur_type == VT_ERROR)
                r = make_item(ITEM_HEADER, cur_type, 32'd1, 8'd0, 1'b0, NS_OK);
            else if (cur_type == VT_UNKNOWN)
                r = make_item(ITEM_HEADER, VT_UNKNOWN, 32'd0, 8'd0, 1'b0, NS_OK);
            else if (cur_type == VT_BULK && null_blk)
                r = make_item(ITEM_HEADER, VT_ERROR, 32'd0, 8'd0, 1'b0, NS_OK);
            else
            begin
                status = NS_OK;
                if (!got_digit)
                    status = NS_NODIGITS;
                else if (ovf || (!neg && acc == MAG_LIMIT))
                    status = NS_OVERFLOW;
                val = '0;
                if (status == NS_OK)
                    val = neg ? (64'd0 - acc) : acc;
                r = make_item(ITEM_HEADER, cur_type, val[31:0], 8'd0, 1'b0, status);
                if (cur_type == VT_BULK && status == NS_OK)
                begin
                    pay_left = val[30:0];
                    if (pay_left != '0)
                        ps_phase = PH_PAYLOAD;
                    else
                    begin
                        trail_left = 2'd2;
                        ps_phase   = PH_TRAILER;
                    end
                end
            end
            return 1'b1;
        end

        // CR waits for LF; it also ends a number
        if (b == CH_CR)
        begin
            cr_held = 1'b1;
            if (cur_type == VT_INTEGER || cur_type == VT_BULK || cur_type == VT_ARRAY)
            begin
                num_done = 1'b1;
                at_first = 1'b0;
            end
            return 1'b0;
        end
        cr_held = 1'b0;

        // simple and error text is echoed
        if (cur_type == VT_SIMPLE || cur_type == VT_ERROR)
        begin
            at_first = 1'b0;
            r = make_item(ITEM_CONTENT, cur_type, 32'd0, b, 1'b0, NS_OK);
            return 1'b1;
        end
        if (cur_type == VT_UNKNOWN)
        begin
            at_first = 1'b0;
            return 1'b0;
        end

        // decimal size: sign, digits, stop at first non-digit
        if (!null_blk)
        begin
            if (at_first && cur_type == VT_BULK && b == CH_MINUS)
                null_blk = 1'b1;
            else if (at_first && (b == CH_PLUS || b == CH_MINUS))
                neg = (b == CH_MINUS);
            else if (!num_done && b >= CH_ZERO && b <= CH_NINE)
            begin
                digit     = 64'(b - CH_ZERO);
                got_digit = 1'b1;
                if (!ovf)
                begin
                    if (acc > (MAG_LIMIT - digit) / 64'd10)
                        ovf = 1'b1;
                    else
                        acc = acc * 64'd10 + digit;
                end
            end
            else
                num_done = 1'b1;
        end
        at_first = 1'b0;
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED)
            $display("ERROR @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                      results_seen, name, got, want));
    endtask

    // Scoreboard: check the output transaction first, then predict the input one
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                seen_item = make_item(item_kind, value_type, size_value, content_byte,
                                      last_content, number_status);
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              results_seen));
                else
                begin
                    want_item = pending_results.pop_front();
                    check_field("item_kind", seen_item.kind, want_item.kind);
                    check_field("value_type", seen_item.vtype, want_item.vtype);
                    check_field("size_value", seen_item.size_val, want_item.size_val);
                    check_field("content_byte", seen_item.data, want_item.data);
                    check_field("last_content", seen_item.last_flag, want_item.last_flag);
                    check_field("number_status", seen_item.status, want_item.status);
                end
                if (seen_item.kind == ITEM_HEADER)
                    headers_seen++;
                else
                    contents_seen++;
                results_seen++;
            end
            if (in_valid && !in_stall)
            begin
                bytes_in++;
                if (parse_byte(in_byte, new_item))
                    pending_results.push_back(new_item);
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_count = 0;
            else
                idle_count++;
            if (idle_count >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Receiver back-pressure
    always @(negedge clk)
    begin
        case (rx_mode)
            RX_READY:  out_stall <= 1'b0;
            RX_RANDOM: out_stall <= ($urandom_range(0, 99) < 40);
            default:
            begin
                out_stall <= stall_pat[pat_pos];
                pat_pos   <= pat_pos + 4'd1;
                if (pat_pos == 4'd15)
                    stall_pat <= 16'($urandom);
            end
        endcase
    end

    // Send one byte in bursts with random gaps; holds until accepted
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 32);
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        in_byte  <= b;
        bytes_sent++;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_random_bytes(input int n, input bit printable);
        for (int i = 0; i < n; i++)
            send_byte(printable ? 8'($urandom_range(32, 126)) : 8'($urandom_range(0, 255)));
    endtask

    // Decimal text for a size or integer line, biased toward the limits
    function automatic string rand_number_text();
        logic [63:0] mag;
        string s;
        case ($urandom_range(0, 9))
            0:       mag = 64'd0;
            1:       mag = 64'd2147483647;
            2:       mag = 64'd2147483648;
            3:       mag = 64'd2147483649 + 64'($urandom_range(0, 1000));
            4:       mag = {$urandom, $urandom} % 64'd100000000000000;
            5, 6:    mag = 64'($urandom);
            default: mag = 64'($urandom_range(0, 999));
        endcase
        s = $sformatf("%0d", mag);
        if ($urandom_range(0, 7) == 0)
            s = {"00", s};
        case ($urandom_range(0, 5))
            0:       s = {"-", s};
            1:       s = {"+", s};
            default: ;
        endcase
        return s;
    endfunction

    // One random value: mostly well formed, some broken lines and noise
    task automatic send_random_value();
        int n;
        logic [7:0] b;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4:
            begin
                send_byte(($urandom_range(0, 2) == 0) ? CH_MINUS : CH_PLUS);
                send_random_bytes($urandom_range(0, 8), $urandom_range(0, 3) != 0);
                send_text("\r\n");
            end
            5, 6, 7:
            begin
                send_byte(CH_COLON);
                send_text(rand_number_text());
                if ($urandom_range(0, 7) == 0)
                    send_text("x9");
                send_text("\r\n");
            end
            8, 9, 10, 11:
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
                send_byte(CH_DOLLAR);
                if ($urandom_range(0, 5) == 0)
                    send_byte(CH_PLUS);
                send_text($sformatf("%0d\r\n", n));
                send_random_bytes(n, 1'b0);
                if ($urandom_range(0, 4) != 0)
                    send_text("\r\n");
                else
                    send_random_bytes(2, 1'b0);
            end
            12, 13:
            begin
                send_byte(CH_STAR);
                send_text(rand_number_text());
                send_text("\r\n");
            end
            14:
            begin
                send_text("$-");
                send_random_bytes($urandom_range(0, 3), 1'b1);
                send_text("\r\n");
            end
            15:
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CH_PLUS || b == CH_MINUS || b == CH_COLON ||
                       b == CH_DOLLAR || b == CH_STAR);
                send_byte(b);
                send_random_bytes($urandom_range(0, 5), 1'b0);
                send_text("\r\n");
            end
            16, 17:
                send_random_bytes($urandom_range(1, 8), 1'b0);
            18:
            begin
                case ($urandom_range(0, 3))
                    0:       send_text(":12\r34\n\r\n");
                    1:       send_text("+ab\r\rc\n\r\n");
                    2:       send_text(":\n7\r\n");
                    default: send_text("*5\r\r\r\n");
                endcase
            end
            default:
            begin
                if ($urandom_range(0, 1) == 0)
                    send_text("$abc\r\n");
                else
                    send_text("$99999999999\r\n");
            end
        endcase
    endtask

    // Each value type, plus extreme type and text bytes
    task automatic test_value_types();
        gap_max = 0;
        rx_mode = RX_READY;
        send_text("+OK\r\n");
        send_text("-ERR bad\r\n");
        send_text(":42\r\n");
        send_text("$3\r\nabc\r\n");
        send_text("*2\r\n");
        send_text("?zz\r\n");
        send_byte(8'h00);
        send_text("\r\n");
        send_byte(8'hFF);
        send_text("q\r\n");
        send_byte(CH_PLUS);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("\r\n");
    endtask

    // Signed limits, overflow, missing digits, sign handling
    task automatic test_number_limits();
        gap_max = 3;
        rx_mode = RX_RANDOM;
        send_text(":2147483647\r\n");
        send_text(":-2147483648\r\n");
        send_text(":2147483648\r\n");
        send_text(":-2147483649\r\n");
        send_text(":99999999999\r\n");
        send_text(":\r\n");
        send_text(":-\r\n");
        send_text(":+17\r\n");
        send_text(":12a34\r\n");
        send_text(":-0\r\n");
        send_text(":007\r\n");
        send_text(":1-2\r\n");
        send_text("*-1\r\n");
        send_text("*0\r\n");
    endtask

    // Zero length, null, bad size and payloads holding line bytes
    task automatic test_bulk_strings();
        gap_max = 6;
        rx_mode = RX_PATTERN;
        send_text("$0\r\n\r\n");
        send_text("$-1\r\n");
        send_text("$-\r\n");
        send_text("$x\r\n");
        send_text("$\r\n");
        send_text("$99999999999\r\n");
        send_text("$+2\r\nhi\r\n");
        send_text("$1\r\nZ\r\n");
        send_text("$4\r\n");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_text("XY");
    endtask

    // Lone CR, repeated CR, bare LF inside header lines
    task automatic test_line_endings();
        gap_max = 2;
        rx_mode = RX_RANDOM;
        send_text("+a\rb\r\r\n");
        send_text("+x\ny\r\n");
        send_text(":1\r2\r\n");
        send_text(":\n5\r\n");
        send_text("-\r\n");
        send_text("+\r\n");
        send_text("*3\r\r\n");
        send_text("?\r\r\n");
    endtask

    // Random traffic in segments with changing idle styles
    task automatic test_random_traffic();
        int stop_at;
        int seg_end;
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at)
        begin
            seg_end = bytes_sent + $urandom_range(60, 140);
            rx_mode = rx_mode_e'($urandom_range(0, 2));
            case ($urandom_range(0, 3))
                0:       gap_max = 0;
                1:       gap_max = 2;
                2:       gap_max = 8;
                default: gap_max = 20;
            endcase
            while (bytes_sent < seg_end && bytes_sent < stop_at)
                send_random_value();
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_byte        = 8'h00;
        out_stall      = 1'b0;
        rx_mode        = RX_READY;
        stall_pat      = 16'hA5C3;
        pat_pos        = 4'd0;
        gap_max        = 0;
        burst_left     = 0;
        mismatch_count = 0;
        bytes_sent     = 0;
        bytes_in       = 0;
        results_seen   = 0;
        headers_seen   = 0;
        contents_seen  = 0;
        idle_count     = 0;
        ps_phase       = PH_TYPE;
        cur_type       = VT_SIMPLE;
        neg            = 1'b0;
        acc            = '0;
        got_digit      = 1'b0;
        num_done       = 1'b0;
        ovf            = 1'b0;
        at_first       = 1'b0;
        null_blk       = 1'b0;
        cr_held        = 1'b0;
        pay_left       = '0;
        trail_left     = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_value_types();
        test_number_limits();
        test_bulk_strings();
        test_line_endings();
        test_random_traffic();

        // drain
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run: %0d stream bytes in, %0d results checked (%0d headers, %0d content)",
                 bytes_in, results_seen, headers_seen, contents_seen);
        $display("Covered all value types, size limits, null/zero/bad bulks, CR/LF oddities");
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
